### rtl/core/egcd_pkg.sv
// Shared widths, limits and control types of the extended gcd unit.
package egcd_pkg;

  // Operand and remainder width, coefficient width, step counter width
  localparam int OPND_W = 31;
  localparam int COEF_W = 32;
  localparam int STEP_W = 7;

  // Most division steps done for one operand pair
  localparam logic [STEP_W-1:0] STEP_LIMIT = 7'd64;

  // Divider iteration counter: one quotient bit per cycle
  localparam int DIV_CNT_W = $clog2(OPND_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(OPND_W - 1);

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Multiply-subtract unit control from the sequencer
  typedef struct packed {
    logic load;   // register the product of quotient and selected coefficient
    logic sel_v;  // 0: u coefficients, 1: v coefficients
  } ms_ctl_t;

endpackage

### rtl/core/egcd_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module egcd_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [egcd_pkg::OPND_W-1:0]  dividend,
  input  logic [egcd_pkg::OPND_W-1:0]  divisor,
  output logic [egcd_pkg::OPND_W-1:0]  quotient,
  output logic [egcd_pkg::OPND_W-1:0]  remainder,
  output egcd_pkg::div_stat_t          stat
);

  logic                            busy;
  logic [egcd_pkg::DIV_CNT_W-1:0]  cnt;
  logic [egcd_pkg::OPND_W-1:0]     part;
  logic [egcd_pkg::OPND_W-1:0]     quo;
  logic [egcd_pkg::OPND_W:0]       trial;
  logic [egcd_pkg::OPND_W:0]       trial_diff;
  logic                            trial_ge;

  // Shift in the next dividend bit and try the subtraction
  assign trial      = {part, quo[egcd_pkg::OPND_W-1]};
  assign trial_diff = trial - {1'b0, divisor};
  assign trial_ge   = (trial >= {1'b0, divisor});

  // Count the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == egcd_pkg::DIV_LAST) begin
        busy <= 1'b0;
      end
      cnt <= cnt + 1'b1;
    end
  end

  // Advance partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      part <= '0;
      quo  <= dividend;
    end else if (busy) begin
      part <= trial_ge ? trial_diff[egcd_pkg::OPND_W-1:0] : trial[egcd_pkg::OPND_W-1:0];
      quo  <= {quo[egcd_pkg::OPND_W-2:0], trial_ge};
    end
  end

  assign quotient  = quo;
  assign remainder = part;
  assign stat.busy = busy;
  assign stat.done = busy && (cnt == egcd_pkg::DIV_LAST);

endmodule

### rtl/core/egcd_mulsub.sv
// Shared multiply-subtract unit for the Bezout coefficient update.
module egcd_mulsub (
  input  logic                         clk,
  input  egcd_pkg::ms_ctl_t            ctl,
  input  logic [egcd_pkg::OPND_W-1:0]  quotient,
  input  logic [egcd_pkg::COEF_W-1:0]  u_prev,
  input  logic [egcd_pkg::COEF_W-1:0]  u_cur,
  input  logic [egcd_pkg::COEF_W-1:0]  v_prev,
  input  logic [egcd_pkg::COEF_W-1:0]  v_cur,
  output logic [egcd_pkg::COEF_W-1:0]  diff
);

  logic [egcd_pkg::COEF_W-1:0] prod;
  logic [egcd_pkg::COEF_W-1:0] mul_opnd;
  logic [egcd_pkg::COEF_W-1:0] sub_opnd;

  // Select the coefficient pair; the subtraction pairs with the product held
  assign mul_opnd = ctl.sel_v ? v_cur : u_cur;
  assign sub_opnd = ctl.sel_v ? u_prev : v_prev;

  // Register the low word of quotient times coefficient
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod <= {{(egcd_pkg::COEF_W - egcd_pkg::OPND_W){1'b0}}, quotient} * mul_opnd;
    end
  end

  // Previous coefficient minus the held product, wrapping
  assign diff = sub_opnd - prod;

endmodule

### rtl/core/extended_gcd_unit.sv
// Extended gcd unit: sequencer, working registers, result register and checks.
//
// Takes two 31-bit non-negative operands, orders them so the dividend is the
// larger, and runs the extended Euclidean algorithm, returning the gcd, the
// Bezout coefficients of the larger and smaller operand, the number of division
// steps and a swap flag. One operand pair is worked on at a time; in_stall is
// high from the transfer until the result is in the output register, which
// frees the input while that result waits to be taken. Each division step
// passes through a check state, the restoring divider at one quotient bit per
// cycle, two passes through the shared multiply-subtract unit and an update
// state. The result is registered in the check state after the last step once
// the output register is free, and the next input transfer can follow from
// idle, steps being 0 to 44 for 31-bit operands. A zero divisor gives the
// dividend as gcd with coefficients 1 and 0 and no steps.
module extended_gcd_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [egcd_pkg::OPND_W-1:0]         first_value,
  input  logic [egcd_pkg::OPND_W-1:0]         second_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [egcd_pkg::OPND_W-1:0]         gcd_value,
  output logic signed [egcd_pkg::COEF_W-1:0]  coef_larger,
  output logic signed [egcd_pkg::COEF_W-1:0]  coef_smaller,
  output logic [egcd_pkg::STEP_W-1:0]         step_count,
  output logic                                was_swapped
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CHK  = 6'b000010,
    S_DIV  = 6'b000100,
    S_MULU = 6'b001000,
    S_MULV = 6'b010000,
    S_UPD  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [egcd_pkg::OPND_W-1:0]  rem_prev;
  logic [egcd_pkg::OPND_W-1:0]  rem_cur;
  logic [egcd_pkg::COEF_W-1:0]  u_prev;
  logic [egcd_pkg::COEF_W-1:0]  u_cur;
  logic [egcd_pkg::COEF_W-1:0]  v_prev;
  logic [egcd_pkg::COEF_W-1:0]  v_cur;
  logic [egcd_pkg::COEF_W-1:0]  u_new;
  logic [egcd_pkg::STEP_W-1:0]  steps_done;
  logic                         swapped;

  logic                         in_xfer;
  logic                         out_free;
  logic                         loop_end;
  logic                         fin;
  logic                         operands_swap;

  logic                         div_start;
  logic [egcd_pkg::OPND_W-1:0]  div_quo;
  logic [egcd_pkg::OPND_W-1:0]  div_rem;
  egcd_pkg::div_stat_t          div_stat;

  egcd_pkg::ms_ctl_t            ms_ctl;
  logic [egcd_pkg::COEF_W-1:0]  ms_diff;

  // Handshake and loop conditions
  assign in_stall      = (state != S_IDLE);
  assign in_xfer       = in_valid && !in_stall;
  assign out_free      = !out_valid || !out_stall;
  assign loop_end      = (rem_cur == '0) || (steps_done == egcd_pkg::STEP_LIMIT);
  assign fin           = (state == S_CHK) && loop_end && out_free;
  assign operands_swap = (second_value > first_value);
  assign div_start     = (state == S_CHK) && !loop_end;

  // Drive the shared multiply-subtract unit: u product first, v product while u settles
  assign ms_ctl.load  = (state == S_MULU) || (state == S_MULV);
  assign ms_ctl.sel_v = (state == S_MULV);

  egcd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rem_prev),
    .divisor   (rem_cur),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  egcd_mulsub u_mulsub (
    .clk      (clk),
    .ctl      (ms_ctl),
    .quotient (div_quo),
    .u_prev   (u_prev),
    .u_cur    (u_cur),
    .v_prev   (v_prev),
    .v_cur    (v_cur),
    .diff     (ms_diff)
  );

  // Sequence one division step after another
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (!loop_end) begin
          state_next = S_DIV;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_next = S_MULU;
        end
      end
      S_MULU:  state_next = S_MULV;
      S_MULV:  state_next = S_UPD;
      S_UPD:   state_next = S_CHK;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Load the ordered operands, then advance the remainder and coefficient pairs
  always_ff @(posedge clk) begin
    if (rst) begin
      steps_done <= '0;
    end else if (in_xfer) begin
      steps_done <= '0;
    end else if (state == S_UPD) begin
      steps_done <= steps_done + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rem_prev <= operands_swap ? second_value : first_value;
      rem_cur  <= operands_swap ? first_value : second_value;
      u_prev   <= egcd_pkg::COEF_W'(1);
      u_cur    <= '0;
      v_prev   <= '0;
      v_cur    <= egcd_pkg::COEF_W'(1);
      swapped  <= operands_swap;
    end else if (state == S_MULV) begin
      u_new <= ms_diff;
    end else if (state == S_UPD) begin
      rem_prev <= rem_cur;
      rem_cur  <= div_rem;
      u_prev   <= u_cur;
      u_cur    <= u_new;
      v_prev   <= v_cur;
      v_cur    <= ms_diff;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      gcd_value    <= rem_prev;
      coef_larger  <= u_prev;
      coef_smaller <= v_prev;
      step_count   <= steps_done;
      was_swapped  <= swapped;
    end
  end

`ifndef SYNTHESIS
  // The divider runs only while the sequencer waits on it
  a_div_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == S_DIV))
    else $error("divider busy outside the divide state");

  // No division is started with a zero divisor
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (rem_cur != '0))
    else $error("division started with zero divisor");

  // The step count never passes its limit
  a_step_limit: assert property (@(posedge clk) disable iff (rst)
    steps_done <= egcd_pkg::STEP_LIMIT)
    else $error("step count beyond limit");

  // A finished item shows up as a valid result next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    fin |=> out_valid && (state == S_IDLE))
    else $error("finished item not presented");
`endif

endmodule
